// ===== hdl/mfbq_pkg.sv =====
// Shared constants and types for the max-first bucket priority queue.
package mfbq_pkg;

    // Queue geometry.
    localparam int TILE_COUNT = 65536;
    localparam int BUCKETS    = 257;

    // Derived widths: tile address, link (tile or empty marker), bucket address.
    localparam int TILE_AW = $clog2(TILE_COUNT);
    localparam int LINK_W  = $clog2(TILE_COUNT + 1);
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam int TOP_W   = BKT_AW + 1;
    localparam int CNT_W   = $clog2(TILE_COUNT + 1);

    // Fixed field widths of the stream payloads.
    localparam int TILE_FW = 16;
    localparam int DIST_FW = 9;
    localparam int KIND_FW = 2;
    localparam int LIVE_FW = 17;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Operation codes carried in tuser.
    typedef enum logic [KIND_FW-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_POP   = 2'd2
    } kind_t;

endpackage

// ===== hdl/mfbq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hdl/max_first_bucket_queue_top.sv =====
// Top level of the max-first bucket priority queue of tile indices.
// Push: the input transfer is followed by the check/write state, then the output load.
// Pop: step past each empty bucket, then unlink the head found and load the output;
// with no head found or no top mark, only the output is loaded. Clear: all in-queue marks
// are swept, then the output is loaded. One item at a time; s_tready returns once the result
// is loaded. After reset every in-queue mark is swept before the first transfer.
module max_first_bucket_queue_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tile [15:0], dist_req [24:16], tile_done [25], zeros [31:26]
    input  logic [mfbq_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [mfbq_pkg::KIND_FW-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // accepted [0], pop_valid [1], pop_tile [17:2], queue_empty [18],
    // live_count [35:19], zeros [39:36]
    output logic [mfbq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import mfbq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SWEEP    = 6'b000010,
        ST_PUSH_CHK = 6'b000100,
        ST_POP_HEAD = 6'b001000,
        ST_POP_LINK = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    localparam logic [LINK_W-1:0]  HEAD_EMPTY = LINK_W'(TILE_COUNT);
    localparam logic [TILE_AW-1:0] SWEEP_LAST = TILE_AW'(TILE_COUNT - 1);
    localparam logic [TOP_W-1:0]   TOP_NONE   = '1;

    // Control state.
    state_t                    state_reg, state_next;
    logic signed [TOP_W-1:0]   top_reg, top_next;
    logic [CNT_W-1:0]          total_reg, total_next;
    logic [BUCKETS-1:0]        hvld_reg, hvld_next;
    logic [TILE_AW-1:0]        sweep_cnt_reg, sweep_cnt_next;
    logic                      sweep_rpt_reg, sweep_rpt_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Payload state.
    logic [TILE_AW-1:0]        work_tile_reg, work_tile_next;
    logic [BKT_AW-1:0]         dist_reg, dist_next;
    logic                      refuse_reg, refuse_next;
    logic                      hvld_q_reg, hvld_q_next;
    logic                      res_acc_reg, res_acc_next;
    logic                      res_pv_reg, res_pv_next;
    logic [TILE_FW-1:0]        res_tile_reg, res_tile_next;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic                      head_we;
    logic [BKT_AW-1:0]         head_waddr, head_raddr;
    logic [LINK_W-1:0]         head_wdata, head_rdata;
    logic                      link_we;
    logic [TILE_AW-1:0]        link_waddr, link_raddr;
    logic [LINK_W-1:0]         link_wdata, link_rdata;
    logic                      mark_we;
    logic [TILE_AW-1:0]        mark_waddr, mark_raddr;
    logic [0:0]                mark_wdata, mark_rdata;

    // Input fields and helpers.
    logic                      in_xfer;
    kind_t                     in_kind;
    logic [TILE_FW-1:0]        in_tile;
    logic [DIST_FW-1:0]        in_dist;
    logic                      in_done;
    logic                      out_free;
    logic [LINK_W-1:0]         head_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_kind  = kind_t'(s_tuser);
    assign in_tile  = s_tdata[TILE_FW-1:0];
    assign in_dist  = s_tdata[TILE_FW +: DIST_FW];
    assign in_done  = s_tdata[TILE_FW + DIST_FW];
    assign out_free = !m_tvalid_reg || m_tready;

    // A bucket not written since the last clear reads as empty.
    assign head_val = hvld_q_reg ? head_rdata : HEAD_EMPTY;

    // Bucket heads, tile links and in-queue marks.
    mfbq_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    mfbq_ram #(.WIDTH(LINK_W), .DEPTH(TILE_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mfbq_ram #(.WIDTH(1), .DEPTH(TILE_COUNT)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // Sequencer: one operation at a time, sharing the top-mark decrement and compare.
    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        total_next     = total_reg;
        hvld_next      = hvld_reg;
        sweep_cnt_next = sweep_cnt_reg;
        sweep_rpt_next = sweep_rpt_reg;
        work_tile_next = work_tile_reg;
        dist_next      = dist_reg;
        refuse_next    = refuse_reg;
        res_acc_next   = res_acc_reg;
        res_pv_next    = res_pv_reg;
        res_tile_next  = res_tile_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        head_we    = 1'b0;
        head_waddr = dist_reg;
        head_wdata = {1'b0, work_tile_reg};
        head_raddr = BKT_AW'(top_reg);
        link_we    = 1'b0;
        link_waddr = work_tile_reg;
        link_wdata = head_val;
        link_raddr = TILE_AW'(head_val);
        mark_we    = 1'b0;
        mark_waddr = work_tile_reg;
        mark_wdata = 1'b0;
        mark_raddr = TILE_AW'(in_tile);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_acc_next  = 1'b0;
                    res_pv_next   = 1'b0;
                    res_tile_next = '0;
                    unique case (in_kind)
                        KIND_CLEAR:
                        begin
                            hvld_next      = '0;
                            top_next       = TOP_NONE;
                            total_next     = '0;
                            sweep_cnt_next = '0;
                            sweep_rpt_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        KIND_PUSH:
                        begin
                            work_tile_next = TILE_AW'(in_tile);
                            dist_next      = BKT_AW'(in_dist);
                            refuse_next    = in_done
                                || (32'(in_tile) >= 32'(TILE_COUNT))
                                || (32'(in_dist) >= 32'(BUCKETS));
                            head_raddr     = BKT_AW'(in_dist);
                            state_next     = ST_PUSH_CHK;
                        end
                        KIND_POP:
                        begin
                            // An empty top mark gives an invalid pop at once.
                            if (top_reg < 0)
                            begin
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_POP_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // Clear one in-queue mark per cycle.
                mark_we        = 1'b1;
                mark_waddr     = sweep_cnt_reg;
                mark_wdata     = 1'b0;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    state_next = sweep_rpt_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_PUSH_CHK:
            begin
                // Link the tile at the head of its bucket unless it is refused or already queued.
                if (!refuse_reg && !mark_rdata[0])
                begin
                    link_we                = 1'b1;
                    head_we                = 1'b1;
                    hvld_next[dist_reg]    = 1'b1;
                    mark_we                = 1'b1;
                    mark_wdata             = 1'b1;
                    total_next             = total_reg + 1'b1;
                    res_acc_next           = 1'b1;
                    if ($signed({1'b0, dist_reg}) > top_reg)
                    begin
                        top_next = $signed({1'b0, dist_reg});
                    end
                end
                state_next = ST_EMIT;
            end
            ST_POP_HEAD:
            begin
                // Step down past empty buckets, or fetch the link of the head found.
                if (head_val >= HEAD_EMPTY)
                begin
                    top_next   = top_reg - 1'b1;
                    head_raddr = BKT_AW'(top_reg - 1'b1);
                    if (top_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    work_tile_next = TILE_AW'(head_val);
                    state_next     = ST_POP_LINK;
                end
            end
            ST_POP_LINK:
            begin
                // Unlink the head and drop its in-queue mark.
                head_we                      = 1'b1;
                head_waddr                   = BKT_AW'(top_reg);
                head_wdata                   = link_rdata;
                hvld_next[BKT_AW'(top_reg)]  = 1'b1;
                mark_we                      = 1'b1;
                mark_wdata                   = 1'b0;
                total_next                   = total_reg - 1'b1;
                res_pv_next                  = 1'b1;
                res_tile_next                = TILE_FW'(work_tile_reg);
                state_next                   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load the result register once it is free.
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0,
                                     LIVE_FW'(total_reg),
                                     total_reg == '0,
                                     res_tile_reg,
                                     res_pv_reg,
                                     res_acc_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        hvld_q_next = hvld_reg[head_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            top_reg       <= TOP_NONE;
            total_reg     <= '0;
            hvld_reg      <= '0;
            sweep_cnt_reg <= '0;
            sweep_rpt_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            total_reg     <= total_next;
            hvld_reg      <= hvld_next;
            sweep_cnt_reg <= sweep_cnt_next;
            sweep_rpt_reg <= sweep_rpt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_tile_reg <= work_tile_next;
        dist_reg      <= dist_next;
        refuse_reg    <= refuse_next;
        hvld_q_reg    <= hvld_q_next;
        res_acc_reg   <= res_acc_next;
        res_pv_reg    <= res_pv_next;
        res_tile_reg  <= res_tile_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No top mark means no tile is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg < 0) |-> (total_reg == '0))
        else $error("top mark empty while tiles are queued");

    // The live count never exceeds the number of tiles.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(TILE_COUNT))
        else $error("live count above tile count");

    // No result reports both a push and a pop; an accepted push leaves the queue non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[1])
                         && !(m_tdata_reg[0] && m_tdata_reg[18]))
        else $error("inconsistent result flags");

endmodule

// ===== dv/max_first_bucket_queue_top_test.sv =====
// Self-checking stream testbench for the max-first bucket priority queue.
`timescale 1ns / 100ps

module max_first_bucket_queue_top_test;
    import mfbq_pkg::*;

    // Code 3 on the kind field is not an operation; the block must ignore it.
    localparam logic [KIND_FW-1:0] KIND_UNUSED = 2'd3;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TILE_COUNT);
    localparam int POOL_SIZE = 48;
    localparam int CALM_TAIL = 100;

    // One operation as the sender presents it.
    typedef struct {
        logic [KIND_FW-1:0] kind;
        logic [TILE_FW-1:0] tile;
        logic [DIST_FW-1:0] dist_key;
        logic               done;
        bit                 drain;
    } queue_op_t;

    // One result with the fields of the output transfer.
    typedef struct {
        logic               accepted;
        logic               pop_valid;
        logic [TILE_FW-1:0] pop_tile;
        logic               queue_empty;
        logic [LIVE_FW-1:0] live_count;
    } queue_outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [KIND_FW-1:0]     s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the queue state.
    logic [LINK_W-1:0] head_of [BUCKETS];
    logic [LINK_W-1:0] link_of [TILE_COUNT];
    bit                queued_flag [TILE_COUNT];
    int                top_dist;
    int                live_tiles;

    queue_op_t      op_backlog [$];
    queue_outcome_t pending_outcomes [$];
    queue_op_t      cur_op;
    logic [TILE_FW-1:0] tile_pool [POOL_SIZE];
    int send_gap = 0;
    int stall_left = 0;
    int error_count = 0;

    max_first_bucket_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Empty every bucket and drop all in-queue marks; links stay as they are.
    function automatic void empty_shadow_queue();
        for (int b = 0; b < BUCKETS; b++)
        begin
            head_of[b] = LINK_NONE;
        end
        for (int t = 0; t < TILE_COUNT; t++)
        begin
            queued_flag[t] = 1'b0;
        end
        top_dist = -1;
        live_tiles = 0;
    endfunction

    // Apply one operation to the shadow queue and return the result it yields.
    function automatic queue_outcome_t apply_queue_op(queue_op_t op);
        queue_outcome_t res;
        logic [LINK_W-1:0] h;
        bit found;
        res.accepted = 1'b0;
        res.pop_valid = 1'b0;
        res.pop_tile = '0;
        found = 1'b0;
        if (op.kind == KIND_CLEAR)
        begin
            empty_shadow_queue();
        end
        else if (op.kind == KIND_PUSH)
        begin
            if (op.dist_key < BUCKETS && !queued_flag[op.tile] && !op.done)
            begin
                link_of[op.tile] = head_of[op.dist_key];
                head_of[op.dist_key] = LINK_W'(op.tile);
                queued_flag[op.tile] = 1'b1;
                if (int'(op.dist_key) > top_dist)
                begin
                    top_dist = int'(op.dist_key);
                end
                live_tiles++;
                res.accepted = 1'b1;
            end
        end
        else if (op.kind == KIND_POP)
        begin
            // Walk down past empty buckets until a head is found.
            while (top_dist >= 0 && !found)
            begin
                h = head_of[top_dist];
                if (h == LINK_NONE)
                begin
                    top_dist--;
                end
                else
                begin
                    head_of[top_dist] = link_of[h[TILE_FW-1:0]];
                    queued_flag[h[TILE_FW-1:0]] = 1'b0;
                    live_tiles--;
                    res.pop_valid = 1'b1;
                    res.pop_tile = h[TILE_FW-1:0];
                    found = 1'b1;
                end
            end
        end
        res.queue_empty = (live_tiles == 0);
        res.live_count = LIVE_FW'(live_tiles);
        return res;
    endfunction

    function automatic void add_op(logic [KIND_FW-1:0] kind, logic [TILE_FW-1:0] tile,
                                   logic [DIST_FW-1:0] dist_key, logic done, bit drain);
        queue_op_t op;
        op.kind = kind;
        op.tile = tile;
        op.dist_key = dist_key;
        op.done = done;
        op.drain = drain;
        op_backlog.push_back(op);
    endfunction

    // Random push, mostly of pooled tiles so that repeated pushes get refused.
    function automatic void add_random_push();
        logic [TILE_FW-1:0] tile;
        logic [DIST_FW-1:0] dist_key;
        int r;
        tile = ($urandom_range(0, 3) != 0) ? tile_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : TILE_FW'($urandom);
        r = $urandom_range(0, 19);
        if (r < 2)
        begin
            dist_key = DIST_FW'($urandom_range(BUCKETS, 511));
        end
        else if (r < 8)
        begin
            // A few crowded buckets show the stack order within one distance.
            dist_key = DIST_FW'($urandom_range(0, 3) * 85);
        end
        else
        begin
            dist_key = DIST_FW'($urandom_range(0, BUCKETS - 1));
        end
        add_op(KIND_PUSH, tile, dist_key, ($urandom_range(0, 9) == 0), 1'b0);
    endfunction

    function automatic void check_field(string name, logic [LIVE_FW-1:0] want,
                                        logic [LIVE_FW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Sender: presents the backlog with random gaps and tracks accepted transfers.
    always @(posedge clk)
    begin
        queue_outcome_t res;
        logic next_valid;
        if (rst_n)
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                res = apply_queue_op(cur_op);
                pending_outcomes.push_back(res);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (op_backlog.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 10) - 1;
                end
                else if (op_backlog.size() != 0
                         && !(op_backlog[0].drain && pending_outcomes.size() != 0))
                begin
                    cur_op = op_backlog.pop_front();
                    s_tdata <= {6'b0, cur_op.done, cur_op.dist_key, cur_op.tile};
                    s_tuser <= cur_op.kind;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: checks each result transfer and stalls in random bursts.
    always @(posedge clk)
    begin
        queue_outcome_t want;
        logic next_ready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("accepted", LIVE_FW'(want.accepted), LIVE_FW'(m_tdata[0]));
                    check_field("pop_valid", LIVE_FW'(want.pop_valid), LIVE_FW'(m_tdata[1]));
                    check_field("pop_tile", LIVE_FW'(want.pop_tile), LIVE_FW'(m_tdata[17:2]));
                    check_field("queue_empty", LIVE_FW'(want.queue_empty),
                                LIVE_FW'(m_tdata[18]));
                    check_field("live_count", want.live_count, m_tdata[35:19]);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (op_backlog.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
            end
            m_tready <= next_ready;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        bit growing;
        int r;
        for (int t = 0; t < TILE_COUNT; t++)
        begin
            link_of[t] = '0;
        end
        empty_shadow_queue();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tile_pool[i] = TILE_FW'($urandom);
        end

        // Directed: field extremes, refusals, ordering, empty pops and clear.
        add_op(KIND_POP, 16'hFFFF, 9'h1FF, 1'b1, 1'b0);
        add_op(KIND_PUSH, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'hFFFF, 9'd256, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'hFFFF, 9'd3, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'd5, 9'd256, 1'b1, 1'b0);
        add_op(KIND_PUSH, 16'd7, 9'd257, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'd9, 9'h1FF, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'd100, 9'd256, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'd200, 9'd10, 1'b0, 1'b0);
        add_op(KIND_UNUSED, 16'hFFFF, 9'h1FF, 1'b1, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'h5555, 9'd128, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'hAAAA, 9'd1, 1'b0, 1'b0);
        add_op(KIND_CLEAR, 16'hFFFF, 9'h1FF, 1'b1, 1'b1);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);
        add_op(KIND_PUSH, 16'h5555, 9'd128, 1'b0, 1'b0);
        add_op(KIND_POP, 16'd0, 9'd0, 1'b0, 1'b0);

        // Random: four segments split by clears, alternating fill and drain phases.
        growing = 1'b1;
        for (int i = 0; i < 1000; i++)
        begin
            if (i % 250 == 0 && i != 0)
            begin
                add_op(KIND_CLEAR, TILE_FW'($urandom), DIST_FW'($urandom), 1'($urandom),
                       1'b1);
            end
            if (i % 40 == 0)
            begin
                growing = ~growing;
            end
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                add_op(KIND_UNUSED, TILE_FW'($urandom), DIST_FW'($urandom), 1'($urandom),
                       1'b0);
            end
            else if (r < (growing ? 77 : 27))
            begin
                add_random_push();
            end
            else
            begin
                add_op(KIND_POP, TILE_FW'($urandom), DIST_FW'($urandom), 1'($urandom), 1'b0);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mfbq_pkg.sv
hdl/mfbq_ram.sv
hdl/max_first_bucket_queue_top.sv
dv/max_first_bucket_queue_top_test.sv
